### sv/cigar_region_overlap_filter_macros.svh
// ---------------------------------------------------------------------------
// cigar_region_overlap_filter_macros.svh
// Assertion macros for the CIGAR region filter. Clock and reset come from
// the module that uses them (clk, rst_n).
// ---------------------------------------------------------------------------
`ifndef CIGAR_REGION_OVERLAP_FILTER_MACROS_SVH
`define CIGAR_REGION_OVERLAP_FILTER_MACROS_SVH

// same-cycle implication
`define CROF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crof assertion failed");

// next-cycle implication
`define CROF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crof assertion failed");

`endif

### sv/crof_pkg.sv
// ---------------------------------------------------------------------------
// crof_pkg
// Shared widths, character codes, status codes and record types.
// ---------------------------------------------------------------------------
package crof_pkg;

  localparam int POS_W   = 32;
  localparam int START_W = 31;
  localparam int CHAR_W  = 8;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 32;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // CIGAR characters
  localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CH_M = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_D = 8'h44;
  localparam logic [CHAR_W-1:0] CH_N = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_S = 8'h53;
  localparam logic [CHAR_W-1:0] CH_I = 8'h49;
  localparam logic [CHAR_W-1:0] CH_H = 8'h48;

  // result status
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_MATCH   = 2'd1;
  localparam logic [STAT_W-1:0] ST_X_BEFORE_M = 2'd2;

  // config register indexes
  localparam logic CFG_REGION_START = 1'b0;
  localparam logic CFG_REGION_END   = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0]  cigar_char;
    logic [START_W-1:0] map_start;
    logic               chrom_match;
    logic               last_char;
  } in_item_t;

  // finished record handed from the parser to the result stage
  typedef struct packed {
    logic [START_W-1:0] map_start;
    logic [POS_W-1:0]   span;
    logic               chrom_match;
    logic               match_seen;
    logic               x_before_m;
  } fin_rec_t;

endpackage

### sv/crof_ifs.sv
// ---------------------------------------------------------------------------
// crof_ifs
// Valid/ready channels for CIGAR characters in and record results out.
// ---------------------------------------------------------------------------
interface crof_in_if import crof_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  cigar_char;
  logic [START_W-1:0] map_start;
  logic               chrom_match;
  logic               last_char;

  modport source (output valid, cigar_char, map_start, chrom_match, last_char,
                  input ready);
  modport sink   (input valid, cigar_char, map_start, chrom_match, last_char,
                  output ready);
endinterface

interface crof_out_if import crof_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  end_pos;
  logic [STAT_W-1:0] status;
  logic              selected;
  logic [CNT_W-1:0]  selected_count;

  modport source (output valid, end_pos, status, selected, selected_count,
                  input ready);
  modport sink   (input valid, end_pos, status, selected, selected_count,
                  output ready);
endinterface

### sv/crof_cigar_parse.sv
// ---------------------------------------------------------------------------
// crof_cigar_parse
// Per-character CIGAR parser: length accumulate, span tracking, and the
// finished-record register loaded on the last character.
// ---------------------------------------------------------------------------
module crof_cigar_parse import crof_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,       // word accepted this cycle
  input  in_item_t item,
  input  logic     fin_take,   // result stage consumes fin_r
  output fin_rec_t fin_r,
  output logic     fin_v_r
);

  logic [POS_W-1:0] acc_r, acc_nxt;
  logic             frozen_r, frozen_nxt;
  logic [POS_W-1:0] span_r, span_nxt;
  logic [POS_W-1:0] slm_r, slm_nxt;      // span after latest M
  logic             match_r, match_nxt;
  logic             xseen_r, xseen_nxt;
  logic             xbm_r, xbm_nxt;      // X seen before some M

  logic              is_digit;
  logic [CHAR_W-1:0] dsub;
  logic [POS_W+3:0]  acc_ext;
  logic [POS_W+3:0]  acc_v;
  logic [POS_W-1:0]  acc_sat;
  logic [POS_W:0]    ssum;
  logic [POS_W-1:0]  span_sat;
  logic              close_op;

  assign is_digit = (item.cigar_char >= CH_0) && (item.cigar_char <= CH_9);
  assign dsub     = item.cigar_char - CH_0;
  assign acc_ext  = {4'b0, acc_r};
  // acc * 10 + digit
  assign acc_v    = (acc_ext << 3) + (acc_ext << 1) + {{POS_W{1'b0}}, dsub[3:0]};
  assign acc_sat  = (acc_v > {4'b0, POS_MAX}) ? POS_MAX : acc_v[POS_W-1:0];
  assign ssum     = {1'b0, span_r} + {1'b0, acc_r};
  assign span_sat = ssum[POS_W] ? POS_MAX : ssum[POS_W-1:0];

  always_comb begin
    acc_nxt    = acc_r;
    frozen_nxt = frozen_r;
    span_nxt   = span_r;
    slm_nxt    = slm_r;
    match_nxt  = match_r;
    xseen_nxt  = xseen_r;
    xbm_nxt    = xbm_r;
    close_op   = 1'b0;
    if (is_digit) begin
      if (!frozen_r) begin
        acc_nxt = acc_sat;
      end
    end else begin
      unique case (item.cigar_char)
        CH_M: begin
          span_nxt  = span_sat;
          slm_nxt   = span_sat;
          match_nxt = 1'b1;
          if (xseen_r) begin
            xbm_nxt = 1'b1;
          end
          close_op = 1'b1;
        end
        CH_D, CH_N: begin
          span_nxt = span_sat;
          close_op = 1'b1;
        end
        CH_X: begin
          xseen_nxt = 1'b1;
          close_op  = 1'b1;
        end
        CH_S, CH_I, CH_H: begin
          close_op = 1'b1;
        end
        default: begin
          frozen_nxt = 1'b1;   // junk char: ignore digits until next op
        end
      endcase
      if (close_op) begin
        acc_nxt    = '0;
        frozen_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      frozen_r <= 1'b0;
      span_r   <= '0;
      slm_r    <= '0;
      match_r  <= 1'b0;
      xseen_r  <= 1'b0;
      xbm_r    <= 1'b0;
    end else if (take) begin
      if (item.last_char) begin
        acc_r    <= '0;
        frozen_r <= 1'b0;
        span_r   <= '0;
        slm_r    <= '0;
        match_r  <= 1'b0;
        xseen_r  <= 1'b0;
        xbm_r    <= 1'b0;
      end else begin
        acc_r    <= acc_nxt;
        frozen_r <= frozen_nxt;
        span_r   <= span_nxt;
        slm_r    <= slm_nxt;
        match_r  <= match_nxt;
        xseen_r  <= xseen_nxt;
        xbm_r    <= xbm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (take && item.last_char) begin
      fin_v_r <= 1'b1;
    end else if (fin_take) begin
      fin_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last_char) begin
      fin_r.map_start   <= item.map_start;
      fin_r.span        <= slm_nxt;
      fin_r.chrom_match <= item.chrom_match;
      fin_r.match_seen  <= match_nxt;
      fin_r.x_before_m  <= xbm_nxt;
    end
  end

endmodule

### sv/cigar_region_overlap_filter.sv
// ---------------------------------------------------------------------------
// cigar_region_overlap_filter
// CIGAR end-position calculator and region filter for alignment records.
// ---------------------------------------------------------------------------
// Takes one CIGAR character per input word, with the record's map start and
// chromosome-match flag alongside; the word flagged last_char closes the
// record and yields exactly one output word (end_pos, status, selected,
// selected_count). Throughput is one character per clock while in_word.ready
// is high, set by the per-character length accumulate (acc*10 + digit,
// saturating) and span add that feed the parser state registers. A record
// passes two registers: accepting its last character loads the parser's
// finished-record register, and the result stage, once its output register
// is free or being taken, loads start + span - 1, the region compare and the
// saturating select counter, all registered at the output. Both the
// finished-record register and the output register hold one record each, so
// input keeps flowing while a result waits; in_word.ready drops only when
// both are full and the sink is stalled. Region registers are written
// through cfg_* while idle; the user is bound to this, as the block
// itself does not enforce it.
// ---------------------------------------------------------------------------
`include "cigar_region_overlap_filter_macros.svh"

module cigar_region_overlap_filter import crof_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [START_W-1:0] cfg_wdata,
  crof_in_if.sink            in_word,
  crof_out_if.source         out_word
);

  // config registers
  logic [START_W-1:0] region_start_r;
  logic [START_W-1:0] region_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_end_r   <= {START_W{1'b1}};
    end else if (cfg_we) begin
      if (cfg_idx == CFG_REGION_START) begin
        region_start_r <= cfg_wdata;
      end else begin
        region_end_r <= cfg_wdata;
      end
    end
  end

  // parser stage
  in_item_t item;
  fin_rec_t fin_r;
  logic     fin_v_r;
  logic     fin_adv;     // result stage can take a record
  logic     fin_take;
  logic     in_take;

  assign item.cigar_char  = in_word.cigar_char;
  assign item.map_start   = in_word.map_start;
  assign item.chrom_match = in_word.chrom_match;
  assign item.last_char   = in_word.last_char;

  logic out_v_r;

  assign fin_adv       = !out_v_r || out_word.ready;
  assign fin_take      = fin_v_r && fin_adv;
  assign in_word.ready = !fin_v_r || fin_adv;
  assign in_take       = in_word.valid && in_word.ready;

  crof_cigar_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_take),
    .item     (item),
    .fin_take (fin_take),
    .fin_r    (fin_r),
    .fin_v_r  (fin_v_r)
  );

  // result stage
  logic [STAT_W-1:0] status;
  logic [POS_W:0]    psum;
  logic [POS_W-1:0]  end_raw;
  logic [POS_W-1:0]  end_pos;
  logic [POS_W-1:0]  reg_end_ext;
  logic              sel;
  logic [CNT_W-1:0]  cnt_r, cnt_inc, cnt_nxt;

  logic [POS_W-1:0]  end_pos_r;
  logic [STAT_W-1:0] status_r;
  logic              sel_r;

  always_comb begin
    if (!fin_r.match_seen) begin
      status = ST_NO_MATCH;
    end else if (fin_r.x_before_m) begin
      status = ST_X_BEFORE_M;
    end else begin
      status = ST_OK;
    end
  end

  // start + span, saturating, then minus one (a zero sum stays zero)
  assign psum = {{(POS_W+1-START_W){1'b0}}, fin_r.map_start} + {1'b0, fin_r.span};

  always_comb begin
    if (psum[POS_W]) begin
      end_raw = POS_MAX - POS_W'(1);
    end else if (psum == '0) begin
      end_raw = '0;
    end else begin
      end_raw = psum[POS_W-1:0] - POS_W'(1);
    end
  end

  assign end_pos     = (status == ST_OK) ? end_raw : '0;
  assign reg_end_ext = {{(POS_W-START_W){1'b0}}, region_end_r};

  // in region, or starts before it and runs past its end
  assign sel = fin_r.chrom_match && (fin_r.map_start <= region_end_r) &&
               ((fin_r.map_start >= region_start_r) ||
                ((status == ST_OK) && (end_pos > reg_end_ext)));

  assign cnt_inc = (cnt_r == {CNT_W{1'b1}}) ? cnt_r : cnt_r + CNT_W'(1);
  assign cnt_nxt = sel ? cnt_inc : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      cnt_r   <= '0;
    end else if (fin_take) begin
      out_v_r <= 1'b1;
      cnt_r   <= cnt_nxt;
    end else if (out_word.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      end_pos_r <= end_pos;
      status_r  <= status;
      sel_r     <= sel;
    end
  end

  assign out_word.valid          = out_v_r;
  assign out_word.end_pos        = end_pos_r;
  assign out_word.status         = status_r;
  assign out_word.selected       = sel_r;
  assign out_word.selected_count = cnt_r;

  // checks
  `CROF_ASSERT_IMP(a_err_no_end, out_v_r && (status_r != ST_OK), end_pos_r == '0)
  `CROF_ASSERT_NEXT(a_cnt_mono, 1'b1, cnt_r >= $past(cnt_r))
  `CROF_ASSERT_IMP(a_stall_full, !in_word.ready, fin_v_r && out_v_r)
  `CROF_ASSERT_NEXT(a_fin_hold, fin_v_r && !fin_adv, fin_v_r && $stable(fin_r))

endmodule

### bench/cigar_region_overlap_filter_tb.sv
// ---------------------------------------------------------------------------
// cigar_region_overlap_filter_tb
// Self-checking bench for the CIGAR end-position and region filter: streams
// CIGAR text one character per word, predicts each record's result word and
// checks every result word against it, under random source and sink idling.
// ---------------------------------------------------------------------------
module cigar_region_overlap_filter_tb;
  import crof_pkg::*;

  // one record's expected result word
  typedef struct {
    logic [POS_W-1:0]  end_pos;
    logic [STAT_W-1:0] status;
    logic              selected;
    logic [CNT_W-1:0]  sel_count;
  } rec_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [START_W-1:0] cfg_wdata;

  crof_in_if  in_ch ();
  crof_out_if out_ch ();

  cigar_region_overlap_filter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  // results still owed by the block, oldest first
  rec_result_t due_results[$];

  int mismatches;
  int chars_sent;

  // idle limits per side, changed from phase to phase (0 = no idling)
  int in_gap_max;
  int out_gap_max;

  // shadow of the region registers
  logic [START_W-1:0] reg_lo;
  logic [START_W-1:0] reg_hi;

  // shadow of the per-record parser state
  logic [POS_W-1:0] len_acc;
  logic             len_frozen;
  logic [POS_W-1:0] ref_span;
  logic [POS_W-1:0] span_at_m;
  logic             seen_m;
  logic             seen_x;
  logic             x_before_m;
  logic [CNT_W-1:0] sel_count;

  localparam logic [START_W-1:0] START_MAX = {START_W{1'b1}};

  // -------------------------------------------------------------------------
  // clock, reset and timeout
  // -------------------------------------------------------------------------
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // generous ceiling; a healthy run ends far earlier
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // -------------------------------------------------------------------------
  // mismatch reporting
  // -------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: mismatch %s got 0x%0h want 0x%0h", what, got, want);
    mismatches++;
  endtask

  // -------------------------------------------------------------------------
  // predictor
  // -------------------------------------------------------------------------
  function automatic logic [POS_W-1:0] sat_sum(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_W] ? POS_MAX : s[POS_W-1:0];
  endfunction

  task automatic clear_record_state();
    len_acc    = '0;
    len_frozen = 1'b0;
    ref_span   = '0;
    span_at_m  = '0;
    seen_m     = 1'b0;
    seen_x     = 1'b0;
    x_before_m = 1'b0;
  endtask

  // digit -> grow the length (unless frozen); op -> close it; other -> freeze
  task automatic fold_cigar_char(input logic [CHAR_W-1:0] ch);
    logic [POS_W+4:0] grown;
    logic             closes;
    if (ch >= CH_0 && ch <= CH_9) begin
      if (!len_frozen) begin
        grown   = len_acc * 10 + (ch - CH_0);
        len_acc = (grown > POS_MAX) ? POS_MAX : grown[POS_W-1:0];
      end
    end else begin
      closes = 1'b1;
      case (ch)
        CH_M: begin
          ref_span  = sat_sum(ref_span, len_acc);
          span_at_m = ref_span;
          seen_m    = 1'b1;
          if (seen_x) x_before_m = 1'b1;
        end
        CH_D, CH_N: ref_span = sat_sum(ref_span, len_acc);
        CH_X:       seen_x = 1'b1;
        CH_S, CH_I, CH_H: ;
        default:    closes = 1'b0;
      endcase
      if (closes) begin
        len_acc    = '0;
        len_frozen = 1'b0;
      end else begin
        len_frozen = 1'b1;
      end
    end
  endtask

  // last character taken: form the record's result word and queue it
  task automatic close_cigar_record(input logic [START_W-1:0] start, input logic chrom);
    rec_result_t r;
    logic [POS_W-1:0] reach;
    r.end_pos  = '0;
    r.selected = 1'b0;
    if (!seen_m)         r.status = ST_NO_MATCH;
    else if (x_before_m) r.status = ST_X_BEFORE_M;
    else                 r.status = ST_OK;
    if (r.status == ST_OK) begin
      reach     = sat_sum({{(POS_W-START_W){1'b0}}, start}, span_at_m);
      r.end_pos = (reach == '0) ? '0 : reach - 1'b1;
    end
    // in the region, or starting ahead of it and running past its end
    if (chrom && start <= reg_hi) begin
      if (start >= reg_lo)
        r.selected = 1'b1;
      else if (r.status == ST_OK && r.end_pos > reg_hi)
        r.selected = 1'b1;
    end
    if (r.selected && sel_count != '1) sel_count++;
    r.sel_count = sel_count;
    due_results = {due_results, r};
    clear_record_state();
  endtask

  // -------------------------------------------------------------------------
  // source side: one word per call; valid stays high when the next word
  // follows with no gap
  // -------------------------------------------------------------------------
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic [START_W-1:0] start,
                           input logic chrom, input logic last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cigar_char  <= ch;
    in_ch.map_start   <= start;
    in_ch.chrom_match <= chrom;
    in_ch.last_char   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
    fold_cigar_char(ch);
    if (last) close_cigar_record(start, chrom);
  endtask

  // start and chrom only matter on the last word; earlier words carry noise
  task automatic send_record(input logic [CHAR_W-1:0] text[$],
                             input logic [START_W-1:0] start, input logic chrom);
    for (int i = 0; i < text.size(); i++) begin
      if (i == text.size() - 1)
        send_char(text[i], start, chrom, 1'b1);
      else
        send_char(text[i], START_W'($urandom), 1'($urandom), 1'b0);
    end
  endtask

  task automatic send_text(input string s, input logic [START_W-1:0] start,
                           input logic chrom);
    logic [CHAR_W-1:0] text[$];
    for (int i = 0; i < s.len(); i++) text = {text, CHAR_W'(s[i])};
    send_record(text, start, chrom);
  endtask

  // -------------------------------------------------------------------------
  // sink side: random stall before each result word
  // -------------------------------------------------------------------------
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // result checker: every accepted result word against the oldest expectation
  always @(posedge clk) begin
    rec_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result end_pos", 64'(out_ch.end_pos), 64'(0));
      end else begin
        want = due_results.pop_front();
        if (out_ch.end_pos !== want.end_pos)
          report_mismatch("end_pos", 64'(out_ch.end_pos), 64'(want.end_pos));
        if (out_ch.status !== want.status)
          report_mismatch("status", 64'(out_ch.status), 64'(want.status));
        if (out_ch.selected !== want.selected)
          report_mismatch("selected", 64'(out_ch.selected), 64'(want.selected));
        if (out_ch.selected_count !== want.sel_count)
          report_mismatch("selected_count", 64'(out_ch.selected_count),
                          64'(want.sel_count));
      end
    end
  end

  // -------------------------------------------------------------------------
  // idle and configuration
  // -------------------------------------------------------------------------
  // drop valid, collect every owed word, then cover the two-stage pipe for
  // a record whose last word may still be in flight
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_region(input logic [START_W-1:0] lo, input logic [START_W-1:0] hi);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_REGION_START;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_idx   <= CFG_REGION_END;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
    reg_lo = lo;
    reg_hi = hi;
  endtask

  // -------------------------------------------------------------------------
  // random record shapes
  // -------------------------------------------------------------------------
  function automatic logic [CHAR_W-1:0] pick_op();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CH_M;
      4:          return CH_D;
      5:          return CH_N;
      6:          return CH_I;
      7:          return CH_S;
      8:          return CH_X;
      default:    return CH_H;
    endcase
  endfunction

  // starts cluster around the region edges so both selection paths fire
  function automatic logic [START_W-1:0] pick_start();
    int delta;
    delta = int'($urandom_range(0, 600)) - 300;
    case ($urandom_range(0, 5))
      0:       return START_W'($urandom);
      1:       return reg_lo + START_W'(delta);
      2:       return reg_hi + START_W'(delta);
      3:       return reg_lo - START_W'($urandom_range(1, 400));
      4:       return $urandom_range(0, 1) ? START_MAX : '0;
      default: return START_W'($urandom_range(0, 1000));
    endcase
  endfunction

  // mostly well-formed CIGAR text; some noise chars, trailing digits and
  // fully random short strings
  task automatic build_cigar(output logic [CHAR_W-1:0] text[$]);
    int n_ops;
    int n_dig;
    int pick;
    text = {};
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 4)) text = {text, CHAR_W'($urandom)};
    end else begin
      n_ops = $urandom_range(1, 5);
      repeat (n_ops) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)       n_dig = 0;
        else if (pick < 75) n_dig = $urandom_range(1, 3);
        else if (pick < 94) n_dig = $urandom_range(4, 6);
        else                n_dig = $urandom_range(9, 12);
        repeat (n_dig) begin
          text = {text, CH_0 + CHAR_W'($urandom_range(0, 9))};
          if ($urandom_range(0, 99) < 3) text = {text, CHAR_W'($urandom)};
        end
        text = {text, pick_op()};
      end
      if ($urandom_range(0, 99) < 10)
        repeat ($urandom_range(1, 3)) text = {text, CH_0 + CHAR_W'($urandom_range(0, 9))};
    end
  endtask

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------
  // every op, each status code, region at reset defaults
  task automatic test_op_decode();
    in_gap_max  = 3;
    out_gap_max = 3;
    send_text("1H1I2D1N3M", 31'd100, 1'b1);
    send_text("2X3M", 31'd7, 1'b1);
    send_text("S", START_MAX, 1'b1);
    wait_idle();
  endtask

  // zero span at zero start, frozen digits, trailing digits, saturation
  task automatic test_char_corners();
    in_gap_max  = 0;
    out_gap_max = 0;
    send_text("0M", 31'd0, 1'b1);
    send_text("1*2M7", 31'd5, 1'b0);
    send_text("9999999999M", START_MAX, 1'b1);
    wait_idle();
  endtask

  // random records through a series of region settings and idle modes
  task automatic test_region_sweep();
    logic [CHAR_W-1:0] text[$];
    logic [START_W-1:0] base;
    int phase;
    int phase_end;
    phase = 0;
    while (chars_sent < 2000) begin
      base = START_W'($urandom_range(0, 32'h7FFF_F000));
      case (phase % 6)
        0: write_region('0, START_MAX);
        1: write_region(START_MAX, START_MAX);
        2: write_region('0, '0);
        3: write_region(base, base + START_W'($urandom_range(0, 2000)));
        4: write_region(base + START_W'($urandom_range(1, 500)), base);
        default: write_region(START_W'($urandom), START_W'($urandom));
      endcase
      case ($urandom_range(0, 2))
        0: begin in_gap_max = 0;  out_gap_max = 0;  end
        1: begin in_gap_max = 14; out_gap_max = 14; end
        default: begin
          in_gap_max  = $urandom_range(0, 1) ? 14 : 0;
          out_gap_max = 14 - in_gap_max;
        end
      endcase
      phase_end = chars_sent + 250;
      while (chars_sent < phase_end) begin
        build_cigar(text);
        send_record(text, pick_start(), ($urandom_range(0, 9) < 8));
      end
      phase++;
    end
    wait_idle();
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_REGION_START;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.cigar_char  = '0;
    in_ch.map_start   = '0;
    in_ch.chrom_match = 1'b0;
    in_ch.last_char   = 1'b0;
    mismatches        = 0;
    chars_sent        = 0;
    in_gap_max        = 0;
    out_gap_max       = 0;
    reg_lo            = '0;
    reg_hi            = START_MAX;
    sel_count         = '0;
    clear_record_state();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_op_decode();
    test_char_corners();
    test_region_sweep();

    // tail: let any stray word show up before the verdict
    repeat (8) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch("results never delivered", 64'(due_results.size()), 64'(0));

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/crof_pkg.sv
sv/crof_ifs.sv
sv/crof_cigar_parse.sv
sv/cigar_region_overlap_filter.sv
bench/cigar_region_overlap_filter_tb.sv
